[rtl/trmf_pkg.sv]
package trmf_pkg;

  // Fixed field widths
  localparam int PIX_W    = 8;
  localparam int IMG_W_W  = 11;
  localparam int IMG_H_W  = 13;
  localparam int CFG_W    = 13;
  localparam int CFG_IX_W = 2;

  // Frame height limit and the row counter width it needs
  localparam int MAX_HEIGHT = 4096;
  localparam int ROW_W      = $clog2(MAX_HEIGHT);

  // Register reset values
  localparam logic [IMG_W_W-1:0] IMAGE_WIDTH_RST  = 11'd640;
  localparam logic [IMG_H_W-1:0] IMAGE_HEIGHT_RST = 13'd480;
  localparam logic [IMG_W_W-1:0] TILE_WIDTH_RST   = 11'd2;
  localparam logic [IMG_H_W-1:0] TILE_HEIGHT_RST  = 13'd2;

  // Register indexes on the config port
  typedef enum logic [CFG_IX_W-1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1,
    REG_TILE_WIDTH   = 2'd2,
    REG_TILE_HEIGHT  = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [IMG_W_W-1:0] image_width;
    logic [IMG_H_W-1:0] image_height;
    logic [IMG_W_W-1:0] tile_width;
    logic [IMG_H_W-1:0] tile_height;
  } cfg_regs_t;

  // Per-pixel tile status from the position tracker
  typedef struct packed {
    logic store;  // pixel lies in a complete tile
    logic first;  // first pixel of its tile
    logic eof;    // last pixel of the frame
  } tile_flags_t;

endpackage

[rtl/trmf_tile_tracker.sv]
module trmf_tile_tracker
  import trmf_pkg::*;
#(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                         clk,
  input  logic                         rst,
  input  cfg_regs_t                    cfg,
  input  logic                         start_of_frame,
  input  logic                         advance,
  output logic [$clog2(MAX_WIDTH)-1:0] tile_idx,
  output tile_flags_t                  flags
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int XW = (CW + 1 > IMG_W_W) ? CW + 1 : IMG_W_W;

  logic [CW-1:0]    col, offx, tcol;
  logic [ROW_W-1:0] row, offy;
  logic [CW-1:0]    col_next, offx_next, tcol_next;
  logic [ROW_W-1:0] row_next, offy_next;

  logic [CW-1:0]    col_c, offx_c, tcol_c, start_x;
  logic [ROW_W-1:0] row_c, offy_c, start_y;
  logic [XW-1:0]    w_eff, iw_x, tw_eff;
  logic [IMG_H_W-1:0] h_eff, th_eff;
  logic [XW:0]      sum_x;
  logic [IMG_H_W:0] sum_y;
  logic             full_x, full_y, last_col, last_row;

  // Clamp sizes: zero means one, image capped at the store and row limits
  always_comb begin
    iw_x = XW'(cfg.image_width);
    if (iw_x == '0) begin
      w_eff = XW'(1);
    end else if (iw_x > XW'(MAX_WIDTH)) begin
      w_eff = XW'(MAX_WIDTH);
    end else begin
      w_eff = iw_x;
    end
    if (cfg.image_height == '0) begin
      h_eff = IMG_H_W'(1);
    end else if (cfg.image_height > IMG_H_W'(MAX_HEIGHT)) begin
      h_eff = IMG_H_W'(MAX_HEIGHT);
    end else begin
      h_eff = cfg.image_height;
    end
    tw_eff = (cfg.tile_width == '0) ? XW'(1) : XW'(cfg.tile_width);
    th_eff = (cfg.tile_height == '0) ? IMG_H_W'(1) : cfg.tile_height;
  end

  // Current position, cleared by start of frame
  always_comb begin
    col_c  = start_of_frame ? '0 : col;
    row_c  = start_of_frame ? '0 : row;
    offx_c = start_of_frame ? '0 : offx;
    offy_c = start_of_frame ? '0 : offy;
    tcol_c = start_of_frame ? '0 : tcol;
  end

  // Tile completeness and frame edges; offsets never exceed positions
  always_comb begin
    start_x  = col_c - offx_c;
    start_y  = row_c - offy_c;
    sum_x    = (XW+1)'(start_x) + (XW+1)'(tw_eff);
    sum_y    = (IMG_H_W+1)'(start_y) + (IMG_H_W+1)'(th_eff);
    full_x   = sum_x <= (XW+1)'(w_eff);
    full_y   = sum_y <= (IMG_H_W+1)'(h_eff);
    last_col = (XW'(col_c) + XW'(1)) >= w_eff;
    last_row = (IMG_H_W'(row_c) + IMG_H_W'(1)) >= h_eff;
    tile_idx    = tcol_c;
    flags.store = full_x && full_y;
    flags.first = (offx_c == '0) && (offy_c == '0);
    flags.eof   = last_col && last_row;
  end

  // Counter stepping
  always_comb begin
    col_next  = col_c;
    row_next  = row_c;
    offx_next = offx_c;
    offy_next = offy_c;
    tcol_next = tcol_c;
    if (last_col) begin
      col_next  = '0;
      offx_next = '0;
      tcol_next = '0;
      if (last_row) begin
        row_next  = '0;
        offy_next = '0;
      end else begin
        row_next = row_c + ROW_W'(1);
        if ((IMG_H_W'(offy_c) + IMG_H_W'(1)) >= th_eff) begin
          offy_next = '0;
        end else begin
          offy_next = offy_c + ROW_W'(1);
        end
      end
    end else begin
      col_next = col_c + CW'(1);
      if ((XW'(offx_c) + XW'(1)) >= tw_eff) begin
        offx_next = '0;
        tcol_next = tcol_c + CW'(1);
      end else begin
        offx_next = offx_c + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col  <= '0;
      row  <= '0;
      offx <= '0;
      offy <= '0;
      tcol <= '0;
    end else if (advance) begin
      col  <= col_next;
      row  <= row_next;
      offx <= offx_next;
      offy <= offy_next;
      tcol <= tcol_next;
    end
  end

endmodule

[rtl/trmf_max_stage.sv]
module trmf_max_stage
  import trmf_pkg::*;
#(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         accept,
  input  logic [PIX_W-1:0]             in_pixel,
  input  logic [$clog2(MAX_WIDTH)-1:0] in_idx,
  input  tile_flags_t                  in_flags,
  input  logic                         out_free,
  output logic                         a_valid,
  output logic                         a_move,
  output logic [PIX_W-1:0]             res_pixel,
  output logic                         res_eof
);

  localparam int CW = $clog2(MAX_WIDTH);

  logic [PIX_W-1:0] store_mem [MAX_WIDTH];
  logic [PIX_W-1:0] rd_data;
  logic [PIX_W-1:0] a_pix;
  logic [CW-1:0]    a_idx;
  tile_flags_t      a_flags;
  logic             fwd_hit;
  logic [PIX_W-1:0] fwd_val;
  logic [PIX_W-1:0] kept;
  logic [PIX_W-1:0] a_result;

  assign a_move = a_valid && out_free;

  // Stage register; read data is captured with the beat
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (accept) begin
      a_valid <= 1'b1;
    end else if (a_move) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_pix   <= in_pixel;
      a_idx   <= in_idx;
      a_flags <= in_flags;
      // the item leaving now writes at this edge; the read misses it
      fwd_hit <= a_move && a_flags.store && in_flags.store && (a_idx == in_idx);
      fwd_val <= a_result;
    end
  end

  // Line store of running maxima, one entry per tile column
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_data <= store_mem[in_idx];
    end
    if (a_move && a_flags.store) begin
      store_mem[a_idx] <= a_result;
    end
  end

  // Running maximum; first pixel of a tile loads it, edge tiles pass through
  always_comb begin
    kept = fwd_hit ? fwd_val : rd_data;
    if (a_flags.store && !a_flags.first && (kept > a_pix)) begin
      a_result = kept;
    end else begin
      a_result = a_pix;
    end
  end

  assign res_pixel = a_result;
  assign res_eof   = a_flags.eof;

  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    accept |=> a_valid)
    else $error("accepted beat did not reach the max stage");

  a_fwd_store: assert property (@(posedge clk) disable iff (rst)
    (a_valid && fwd_hit) |-> a_flags.store)
    else $error("forward hit on a beat outside a complete tile");

  a_first_loads: assert property (@(posedge clk) disable iff (rst)
    (a_valid && a_flags.first) |-> (a_result == a_pix))
    else $error("first pixel of a tile did not load its maximum");

endmodule

[rtl/tile_running_max_filter_unit.sv]
// Channel   Signals                                   Direction  Beat
// input     in_valid/in_ready, pixel_in,               in         one pixel
//           start_of_frame
// output    out_valid/out_ready, pixel_out,            out        one pixel
//           end_of_frame
// config    cfg_write, cfg_index, cfg_data             in         one register
//
// One pixel per clock sustained while the output is not stalled; an input beat
// passes the max stage, then the output register, before output valid.
// The line store is read when a beat is taken and written when its result
// leaves the max stage; a same-column result in flight is forwarded.
// Reset (rst, synchronous) clears position counters, stage valids and
// loads the register defaults; the line store is not cleared.
// A stalled output holds its beat while the max stage still takes one more.
module tile_running_max_filter_unit
  import trmf_pkg::*;
#(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [PIX_W-1:0]    pixel_in,
  input  logic                start_of_frame,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [PIX_W-1:0]    pixel_out,
  output logic                end_of_frame,
  input  logic                cfg_write,
  input  logic [CFG_IX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]    cfg_data
);

  localparam int CW = $clog2(MAX_WIDTH);

  cfg_regs_t        cfg;
  logic             accept;
  logic [CW-1:0]    tile_idx;
  tile_flags_t      flags;
  logic             a_valid, a_move, out_free, res_eof;
  logic [PIX_W-1:0] res_pixel;

  // Config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.image_width  <= IMAGE_WIDTH_RST;
      cfg.image_height <= IMAGE_HEIGHT_RST;
      cfg.tile_width   <= TILE_WIDTH_RST;
      cfg.tile_height  <= TILE_HEIGHT_RST;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_IMAGE_WIDTH:  cfg.image_width  <= cfg_data[IMG_W_W-1:0];
        REG_IMAGE_HEIGHT: cfg.image_height <= cfg_data[IMG_H_W-1:0];
        REG_TILE_WIDTH:   cfg.tile_width   <= cfg_data[IMG_W_W-1:0];
        REG_TILE_HEIGHT:  cfg.tile_height  <= cfg_data[IMG_H_W-1:0];
        default: ;
      endcase
    end
  end

  // Handshake
  assign out_free = !out_valid || out_ready;
  assign in_ready = !a_valid || a_move;
  assign accept   = in_valid && in_ready;

  trmf_tile_tracker #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_tracker (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .start_of_frame (start_of_frame),
    .advance        (accept),
    .tile_idx       (tile_idx),
    .flags          (flags)
  );

  trmf_max_stage #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_max (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .in_pixel  (pixel_in),
    .in_idx    (tile_idx),
    .in_flags  (flags),
    .out_free  (out_free),
    .a_valid   (a_valid),
    .a_move    (a_move),
    .res_pixel (res_pixel),
    .res_eof   (res_eof)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (a_move) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (a_move) begin
      pixel_out    <= res_pixel;
      end_of_frame <= res_eof;
    end
  end

  a_move_loads: assert property (@(posedge clk) disable iff (rst)
    a_move |=> out_valid)
    else $error("max stage result lost on the way to the output");

endmodule

[tb/sv/tile_running_max_filter_unit_tb.sv]
`timescale 1ns / 100ps

module tile_running_max_filter_unit_tb;
  import trmf_pkg::*;

  localparam int MAX_WIDTH = 1024;

  // Running tile maximum predictor plus the queue of pixels it expects back
  class tile_max_scoreboard;

    localparam int STORE_DEPTH = 1024;

    typedef struct {
      bit [PIX_W-1:0] pix;
      bit             eof;
    } out_pixel_t;

    // register copies
    bit [IMG_W_W-1:0] img_w;
    bit [IMG_H_W-1:0] img_h;
    bit [IMG_W_W-1:0] tile_w;
    bit [IMG_H_W-1:0] tile_h;

    // position state
    bit [9:0]  col;
    bit [11:0] row;
    bit [9:0]  off_x;
    bit [11:0] off_y;
    bit [9:0]  tile_col;
    bit        x_full;
    bit        y_full;
    bit [PIX_W-1:0] max_store [STORE_DEPTH];

    out_pixel_t expected_pixels[$];
    int mismatches;

    function new();
      img_w    = IMAGE_WIDTH_RST;
      img_h    = IMAGE_HEIGHT_RST;
      tile_w   = TILE_WIDTH_RST;
      tile_h   = TILE_HEIGHT_RST;
      x_full   = 1'b1;
      y_full   = 1'b1;
      mismatches = 0;
      clear_position();
      foreach (max_store[i]) max_store[i] = '0;
    endfunction

    function void clear_position();
      col      = '0;
      row      = '0;
      off_x    = '0;
      off_y    = '0;
      tile_col = '0;
    endfunction

    function void write_reg(cfg_reg_t ix, bit [CFG_W-1:0] v);
      case (ix)
        REG_IMAGE_WIDTH:  img_w  = v[IMG_W_W-1:0];
        REG_IMAGE_HEIGHT: img_h  = v[IMG_H_W-1:0];
        REG_TILE_WIDTH:   tile_w = v[IMG_W_W-1:0];
        REG_TILE_HEIGHT:  tile_h = v[IMG_H_W-1:0];
        default: ;
      endcase
    endfunction

    function bit at_frame_start();
      return col == 0 && row == 0;
    endfunction

    function int pending();
      return expected_pixels.size();
    endfunction

    // sizes of zero act as one; image size saturates at the store depth / max height
    function int unsigned clamp_dim(int unsigned v, int unsigned hi);
      if (v == 0) return 1;
      return (v > hi) ? hi : v;
    endfunction

    // one accepted input beat -> one expected output pixel
    function void note_pixel(bit [PIX_W-1:0] pix, bit sof);
      int unsigned w, h, tw, th, sx, sy;
      bit [PIX_W-1:0] res;
      bit last_c, last_r;
      out_pixel_t item;

      w  = clamp_dim(img_w, STORE_DEPTH);
      h  = clamp_dim(img_h, MAX_HEIGHT);
      tw = (tile_w == 0) ? 1 : tile_w;
      th = (tile_h == 0) ? 1 : tile_h;
      res = pix;

      if (sof) clear_position();

      sx = (off_x <= col) ? col - off_x : 0;
      sy = (off_y <= row) ? row - off_y : 0;
      x_full = (sx + tw) <= w;
      y_full = (sy + th) <= h;

      if (x_full && y_full && tile_col < STORE_DEPTH) begin
        if (off_x == 0 && off_y == 0) begin
          res = pix;
        end else begin
          res = (pix > max_store[tile_col]) ? pix : max_store[tile_col];
        end
        max_store[tile_col] = res;
      end

      last_c = (col + 1) >= w;
      last_r = (row + 1) >= h;
      item.pix = res;
      item.eof = last_c && last_r;
      expected_pixels.push_back(item);

      // advance raster and tile counters
      if (last_c) begin
        col      = '0;
        off_x    = '0;
        tile_col = '0;
        if (last_r) begin
          row   = '0;
          off_y = '0;
        end else begin
          row = row + 12'd1;
          if (off_y + 1 >= th) off_y = '0;
          else off_y = off_y + 12'd1;
        end
      end else begin
        col = col + 10'd1;
        if (off_x + 1 >= tw) begin
          off_x    = '0;
          tile_col = tile_col + 10'd1;
        end else begin
          off_x = off_x + 10'd1;
        end
      end
    endfunction

    task report_mismatch(string msg);
      mismatches++;
      $display("MISMATCH @%0t: %s", $realtime, msg);
    endtask

    // one accepted output beat
    task check_pixel(bit [PIX_W-1:0] pix, bit eof);
      out_pixel_t exp_item;
      if (expected_pixels.size() == 0) begin
        report_mismatch($sformatf("output with nothing pending: pixel %0d eof %0b", pix, eof));
        return;
      end
      exp_item = expected_pixels.pop_front();
      if (pix !== exp_item.pix)
        report_mismatch($sformatf("pixel_out %0d, want %0d", pix, exp_item.pix));
      if (eof !== exp_item.eof)
        report_mismatch($sformatf("end_of_frame %0b, want %0b", eof, exp_item.eof));
    endtask
  endclass

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_ready;
  logic [PIX_W-1:0]    pixel_in;
  logic                start_of_frame;
  logic                out_valid;
  logic                out_ready;
  logic [PIX_W-1:0]    pixel_out;
  logic                end_of_frame;
  logic                cfg_write;
  logic [CFG_IX_W-1:0] cfg_index;
  logic [CFG_W-1:0]    cfg_data;

  bit hold_req;

  tile_max_scoreboard sb;

  tile_running_max_filter_unit #(
    .MAX_WIDTH(MAX_WIDTH)
  ) dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .pixel_in       (pixel_in),
    .start_of_frame (start_of_frame),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .pixel_out      (pixel_out),
    .end_of_frame   (end_of_frame),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // mostly short idle gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // called at a falling edge; returns at a falling edge
  task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic sof, input int gap);
    in_valid       = 1'b1;
    pixel_in       = pix;
    start_of_frame = sof;
    do @(posedge clk); while (!in_ready);
    sb.note_pixel(pix, sof);
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic write_reg(input cfg_reg_t ix, input logic [CFG_W-1:0] v);
    cfg_write = 1'b1;
    cfg_index = ix;
    cfg_data  = v;
    sb.write_reg(ix, v);
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  // wait until every expected pixel has come back
  task automatic drain();
    in_valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_geometry(input int w, input int h, input int tw, input int th);
    drain();
    write_reg(REG_IMAGE_WIDTH, CFG_W'(w));
    write_reg(REG_IMAGE_HEIGHT, CFG_W'(h));
    write_reg(REG_TILE_WIDTH, CFG_W'(tw));
    write_reg(REG_TILE_HEIGHT, CFG_W'(th));
  endtask

  // output side: random ready, one long hold-off on request
  initial begin : receiver
    int run_len;
    int idle;
    out_ready = 1'b0;
    wait (rst == 1'b0);
    forever begin
      if (hold_req) begin
        out_ready = 1'b0;
        repeat (400) @(negedge clk);
        hold_req = 1'b0;
      end
      out_ready = 1'b1;
      run_len = $urandom_range(1, 40);
      repeat (run_len) @(negedge clk);
      idle = pick_gap();
      if (idle > 0) begin
        out_ready = 1'b0;
        repeat (idle) @(negedge clk);
      end
    end
  end

  // output beats
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_pixel(pixel_out, end_of_frame);
  end

  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin : stimulus
    int random_items;
    int kind, w, h, tw, th, n, gap;
    bit quiet, sof;
    logic [PIX_W-1:0] pix;

    sb = new();
    rst            = 1'b1;
    in_valid       = 1'b0;
    pixel_in       = '0;
    start_of_frame = 1'b0;
    cfg_write      = 1'b0;
    cfg_index      = REG_IMAGE_WIDTH;
    cfg_data       = '0;
    hold_req       = 1'b0;
    random_items   = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset geometry 640x480, 2x2 tiles: first pixel loads, next one maxes
    send_pixel(8'h00, 1'b1, 0);
    send_pixel(8'hFF, 1'b0, 1);
    send_pixel(8'h55, 1'b0, 0);
    send_pixel(8'hAA, 1'b0, 2);
    send_pixel(8'h80, 1'b1, 0);

    // all sizes zero act as 1x1: every pixel ends a frame
    set_geometry(0, 0, 0, 0);
    send_pixel(8'h12, 1'b1, 0);
    send_pixel(8'hFF, 1'b0, 0);
    send_pixel(8'h00, 1'b0, 3);

    // tile bigger than the image: everything passes through
    set_geometry(3, 2, 4, 3);
    for (int i = 0; i < 6; i++) send_pixel(PIX_W'($urandom_range(0, 255)), i == 0, 0);

    // oversized image registers saturate
    set_geometry(2047, 8191, 3, 2);
    for (int i = 0; i < 4; i++) send_pixel(PIX_W'($urandom_range(0, 255)), i == 0, 1);

    // width change mid-frame; 1x1 tiles so the line store is always loaded first
    set_geometry(4, 3, 1, 1);
    for (int i = 0; i < 5; i++) send_pixel(PIX_W'($urandom_range(0, 255)), i == 0, 0);
    drain();
    write_reg(REG_IMAGE_WIDTH, CFG_W'(2));
    for (int i = 0; i < 4; i++) send_pixel(PIX_W'($urandom_range(0, 255)), 1'b0, 0);

    // back-pressure phase: receiver stalls long while input keeps coming
    set_geometry(8, 6, 2, 3);
    hold_req = 1'b1;
    for (int i = 0; i < 250; i++) send_pixel(PIX_W'($urandom_range(0, 255)), i == 0, 0);
    random_items += 250;

    // random geometries, mostly small frames with whole-frame streams
    while (random_items < 700) begin
      kind = $urandom_range(0, 9);
      if (kind < 7) begin
        w  = $urandom_range(1, 12);
        h  = $urandom_range(1, 9);
        tw = $urandom_range(0, w + 1);
        th = $urandom_range(0, h + 1);
        n  = w * h * $urandom_range(1, 3) + $urandom_range(0, 3);
        if (n > 150) n = 150;
      end else if (kind == 7) begin
        w  = ($urandom_range(0, 3) == 0) ? 2047 : $urandom_range(1000, 1024);
        h  = $urandom_range(1, 4);
        tw = ($urandom_range(0, 1) == 0) ? 1024 : $urandom_range(1, 40);
        th = $urandom_range(1, h);
        n  = 120;
      end else if (kind == 8) begin
        w  = $urandom_range(1, 3);
        h  = ($urandom_range(0, 3) == 0) ? 8191 : $urandom_range(4000, 4096);
        tw = $urandom_range(1, 2);
        th = ($urandom_range(0, 1) == 0) ? 4096 : $urandom_range(1, 8);
        n  = 100;
      end else begin
        w  = $urandom_range(0, 2047);
        h  = $urandom_range(0, 8191);
        tw = $urandom_range(0, 2047);
        th = $urandom_range(0, 8191);
        n  = 60;
      end
      if (n > 700 - random_items) n = 700 - random_items;
      set_geometry(w, h, tw, th);
      quiet = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < n; i++) begin
        // start marks mostly on real frame starts, a few as noise mid-frame
        if (i == 0) sof = 1'b1;
        else if (sb.at_frame_start()) sof = $urandom_range(0, 1);
        else sof = ($urandom_range(0, 49) == 0);
        pix = ($urandom_range(0, 7) == 0) ? {PIX_W{$urandom_range(0, 1) == 1}}
                                         : PIX_W'($urandom_range(0, 255));
        gap = quiet ? 0 : pick_gap();
        send_pixel(pix, sof, gap);
      end
      random_items += n;
    end

    drain();
    repeat (8) @(posedge clk);
    if (sb.pending() != 0) sb.report_mismatch("expected pixels never came out");
    if (sb.mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

[sim.f]
rtl/trmf_pkg.sv
rtl/trmf_tile_tracker.sv
rtl/trmf_max_stage.sv
rtl/tile_running_max_filter_unit.sv
tb/sv/tile_running_max_filter_unit_tb.sv
